### rtl/buddy_page_allocator_defines.svh
// Assertion macros for the buddy page allocator.
`ifndef BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define BPA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error("lbl");
`define BPA_ASSERT_AFTER_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) else $error("lbl");
`else
`define BPA_ASSERT_IMPL(lbl, ante, cons)
`define BPA_ASSERT_AFTER_RST(lbl, cons)
`endif
`endif

### rtl/bpa_pkg.sv
package bpa_pkg;

  localparam int TOTAL_PAGES = 1024;
  localparam int LEVELS      = 10;
  localparam int NODES       = 2 * TOTAL_PAGES;
  localparam int NODE_W      = 11;
  localparam int CNT_W       = 11;
  localparam int OFS_W       = 10;
  localparam int LV_W        = 4;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_INIT  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_ZERO     = 2'd2;

  typedef logic [4:0] cmd_t;
  localparam cmd_t CMD_NONE       = 5'd0;
  localparam cmd_t CMD_CLR        = 5'd1;
  localparam cmd_t CMD_LOAD       = 5'd2;
  localparam cmd_t CMD_SEED_START = 5'd3;
  localparam cmd_t CMD_SEED_A     = 5'd4;
  localparam cmd_t CMD_SEED_B     = 5'd5;
  localparam cmd_t CMD_RD_ROOT    = 5'd6;
  localparam cmd_t CMD_TAKE_V     = 5'd7;
  localparam cmd_t CMD_SPLIT      = 5'd8;
  localparam cmd_t CMD_SPLIT2     = 5'd9;
  localparam cmd_t CMD_RD_L       = 5'd10;
  localparam cmd_t CMD_RD_R       = 5'd11;
  localparam cmd_t CMD_CHOOSE     = 5'd12;
  localparam cmd_t CMD_TAKE       = 5'd13;
  localparam cmd_t CMD_FAIL       = 5'd14;
  localparam cmd_t CMD_FREE_SET   = 5'd15;
  localparam cmd_t CMD_UP_L       = 5'd16;
  localparam cmd_t CMD_UP_R       = 5'd17;
  localparam cmd_t CMD_UP_W       = 5'd18;
  localparam cmd_t CMD_OUT        = 5'd19;

  typedef struct packed {
    logic       clr_last;
    logic [1:0] op;
    logic       bad;
    logic       seed_more;
    logic       seed_hi;
    logic       descend;
    logic       fits;
    logic       whole;
    logic       pick_ok;
    logic       at_root;
  } bpa_flags_t;

  function automatic logic [LV_W-1:0] ceil_log2(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] m;
    logic [LV_W-1:0]  k;
    m = c - 1'b1;
    k = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (m[i]) k = LV_W'(i + 1);
    end
    return k;
  endfunction

endpackage

### rtl/bpa_ram.sv
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

### rtl/bpa_dp.sv
module bpa_dp
  import bpa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output bpa_flags_t        flags,
  input  logic [23:0]       in_data,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_value,
  output logic [23:0]       out_data
);

  logic [NODE_W-1:0] clr;
  logic [CNT_W-1:0]  usable;
  logic [CNT_W-1:0]  count;
  logic [1:0]        op;
  logic [1:0]        status;
  logic [LV_W-1:0]   k;
  logic [OFS_W-1:0]  base;
  logic [NODE_W-1:0] node;
  logic [LV_W-1:0]   lv;
  logic [CNT_W-1:0]  v;
  logic [CNT_W-1:0]  vl;
  logic [CNT_W-1:0]  rest;
  logic [OFS_W-1:0]  offset;
  logic              merge;
  logic [1:0]        out_status;
  logic [OFS_W-1:0]  out_offset;
  logic [CNT_W-1:0]  out_free;

  logic              we;
  logic [NODE_W-1:0] waddr;
  logic [CNT_W-1:0]  wdata;
  logic [NODE_W-1:0] raddr;
  logic [CNT_W-1:0]  rdata;

  logic [CNT_W-1:0]  len;
  logic [CNT_W-1:0]  span;
  logic [CNT_W-1:0]  half;
  logic [NODE_W-1:0] left;
  logic              pick_r;
  logic              pick_ok;
  logic [CNT_W-1:0]  in_cnt;
  logic [LV_W-1:0]   in_k;
  logic [NODE_W-1:0] node_rel;
  logic [CNT_W:0]    sum;

  assign len      = CNT_W'(1) << k;
  assign span     = CNT_W'(TOTAL_PAGES) >> lv;
  assign half     = span >> 1;
  assign left     = {node[NODE_W-2:0], 1'b0};
  assign in_cnt   = in_data[12:2];
  assign in_k     = ceil_log2(in_cnt);
  assign node_rel = node ^ (NODE_W'(1) << lv);
  assign sum      = {1'b0, count} + {1'b0, len};

  always_comb begin
    pick_ok = 1'b1;
    pick_r  = 1'b0;
    if ((len & vl) != '0) begin
      pick_r = 1'b0;
    end else if ((len & rdata) != '0) begin
      pick_r = 1'b1;
    end else if (len <= vl) begin
      pick_r = 1'b0;
    end else if (len <= rdata) begin
      pick_r = 1'b1;
    end else begin
      pick_ok = 1'b0;
    end
  end

  always_comb begin
    flags.clr_last  = &clr;
    flags.op        = op;
    flags.bad       = (status != ST_OK);
    flags.seed_more = (rest != '0) && (rest < span);
    flags.seed_hi   = rest > half;
    flags.descend   = (len <= v) && (len < span);
    flags.fits      = len <= v;
    flags.whole     = v == span;
    flags.pick_ok   = pick_ok;
    flags.at_root   = node == NODE_W'(1);
  end

  always_comb begin
    we    = 1'b0;
    waddr = node;
    wdata = '0;
    raddr = left;
    case (cmd)
      CMD_CLR: begin
        we    = 1'b1;
        waddr = clr;
      end
      CMD_SEED_START: begin
        we    = 1'b1;
        waddr = NODE_W'(1);
        wdata = (usable > CNT_W'(TOTAL_PAGES)) ? CNT_W'(TOTAL_PAGES) : usable;
      end
      CMD_SEED_A: begin
        we    = 1'b1;
        waddr = left;
        wdata = (rest > half) ? half : rest;
      end
      CMD_SEED_B: begin
        we    = 1'b1;
        wdata = rest;
      end
      CMD_RD_ROOT: raddr = NODE_W'(1);
      CMD_SPLIT: begin
        we    = 1'b1;
        waddr = left;
        wdata = v >> 1;
      end
      CMD_SPLIT2: begin
        we    = 1'b1;
        waddr = left | NODE_W'(1);
        wdata = v >> 1;
      end
      CMD_RD_L: raddr = left;
      CMD_RD_R: raddr = left | NODE_W'(1);
      CMD_TAKE: we = 1'b1;
      CMD_FREE_SET: begin
        we    = 1'b1;
        waddr = NODE_W'({1'b1, base} >> k);
        wdata = len;
      end
      CMD_UP_L: raddr = {node[NODE_W-1:1], 1'b0};
      CMD_UP_R: raddr = left | NODE_W'(1);
      CMD_UP_W: begin
        we = 1'b1;
        if (merge && (vl == half) && (rdata == half)) begin
          wdata = vl << 1;
        end else begin
          wdata = vl | rdata;
        end
      end
      default: ;
    endcase
  end

  bpa_ram #(.WIDTH(CNT_W), .DEPTH(NODES)) u_tree (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr    <= '0;
      usable <= CNT_W'(TOTAL_PAGES);
      count  <= '0;
    end else begin
      if (cfg_we) usable <= cfg_value;
      case (cmd)
        CMD_CLR: clr <= clr + 1'b1;
        CMD_SEED_START: begin
          count <= (usable > CNT_W'(TOTAL_PAGES)) ? CNT_W'(TOTAL_PAGES) : usable;
        end
        CMD_TAKE: count <= (count >= len) ? count - len : '0;
        CMD_FREE_SET: begin
          count <= (sum > (CNT_W+1)'(TOTAL_PAGES)) ? CNT_W'(TOTAL_PAGES) : sum[CNT_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        op     <= in_data[1:0];
        base   <= in_data[22:13];
        k      <= in_k;
        offset <= '0;
        if (in_data[1:0] == OP_ALLOC || in_data[1:0] == OP_FREE) begin
          if (in_cnt == '0) begin
            status <= ST_ZERO;
          end else if (in_cnt > CNT_W'(TOTAL_PAGES)) begin
            status <= ST_NO_SPACE;
          end else begin
            status <= ST_OK;
          end
        end else begin
          status <= ST_OK;
        end
      end
      CMD_SEED_START: begin
        rest <= (usable > CNT_W'(TOTAL_PAGES)) ? CNT_W'(TOTAL_PAGES) : usable;
        node <= NODE_W'(1);
        lv   <= '0;
      end
      CMD_SEED_A: begin
        if (rest > half) begin
          rest <= rest - half;
          node <= left | NODE_W'(1);
        end else begin
          node <= left;
        end
        lv <= lv + 1'b1;
      end
      CMD_RD_ROOT: begin
        node <= NODE_W'(1);
        lv   <= '0;
      end
      CMD_TAKE_V: v <= rdata;
      CMD_SPLIT2: begin
        node <= left;
        lv   <= lv + 1'b1;
        v    <= v >> 1;
      end
      CMD_RD_R: vl <= rdata;
      CMD_CHOOSE: begin
        node <= left | NODE_W'(pick_r);
        lv   <= lv + 1'b1;
        v    <= pick_r ? rdata : vl;
      end
      CMD_TAKE: begin
        offset <= OFS_W'(node_rel << (LV_W'(LEVELS) - lv));
        merge  <= 1'b0;
      end
      CMD_FAIL: status <= ST_NO_SPACE;
      CMD_FREE_SET: begin
        node  <= NODE_W'({1'b1, base} >> k);
        lv    <= LV_W'(LEVELS) - k;
        merge <= 1'b1;
      end
      CMD_UP_L: begin
        node <= node >> 1;
        lv   <= lv - 1'b1;
      end
      CMD_UP_R: vl <= rdata;
      CMD_OUT: begin
        out_status <= status;
        out_offset <= (status == ST_OK) ? offset : '0;
        out_free   <= count;
      end
      default: ;
    endcase
  end

  assign out_data = {1'b0, out_free, out_offset, out_status};

endmodule

### rtl/bpa_ctrl.sv
module bpa_ctrl
  import bpa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  bpa_flags_t flags,
  output cmd_t       cmd,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready
);

  localparam logic [4:0] S_SWEEP_RST  = 5'd0;
  localparam logic [4:0] S_IDLE       = 5'd1;
  localparam logic [4:0] S_DISPATCH   = 5'd2;
  localparam logic [4:0] S_SWEEP_INIT = 5'd3;
  localparam logic [4:0] S_SEED0      = 5'd4;
  localparam logic [4:0] S_SEED       = 5'd5;
  localparam logic [4:0] S_SEED_B     = 5'd6;
  localparam logic [4:0] S_RD_ROOT    = 5'd7;
  localparam logic [4:0] S_TAKE_ROOT  = 5'd8;
  localparam logic [4:0] S_CHECK      = 5'd9;
  localparam logic [4:0] S_SPLIT2     = 5'd10;
  localparam logic [4:0] S_RD_R       = 5'd11;
  localparam logic [4:0] S_CHOOSE     = 5'd12;
  localparam logic [4:0] S_TAKE       = 5'd13;
  localparam logic [4:0] S_FAIL       = 5'd14;
  localparam logic [4:0] S_FREE_SET   = 5'd15;
  localparam logic [4:0] S_UP         = 5'd16;
  localparam logic [4:0] S_UP_R       = 5'd17;
  localparam logic [4:0] S_UP_W       = 5'd18;
  localparam logic [4:0] S_FIN        = 5'd19;

  logic [4:0] state;
  logic [4:0] state_next;
  logic       out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    cmd            = CMD_NONE;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_SWEEP_RST: begin
        cmd = CMD_CLR;
        if (flags.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd        = CMD_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (flags.op == OP_INIT) begin
          state_next = S_SWEEP_INIT;
        end else if (flags.op == OP_NOP || flags.bad) begin
          state_next = S_FIN;
        end else if (flags.op == OP_ALLOC) begin
          state_next = S_RD_ROOT;
        end else begin
          state_next = S_FREE_SET;
        end
      end
      S_SWEEP_INIT: begin
        cmd = CMD_CLR;
        if (flags.clr_last) state_next = S_SEED0;
      end
      S_SEED0: begin
        cmd        = CMD_SEED_START;
        state_next = S_SEED;
      end
      S_SEED: begin
        if (flags.seed_more) begin
          cmd        = CMD_SEED_A;
          state_next = flags.seed_hi ? S_SEED_B : S_SEED;
        end else begin
          state_next = S_FIN;
        end
      end
      S_SEED_B: begin
        cmd        = CMD_SEED_B;
        state_next = S_SEED;
      end
      S_RD_ROOT: begin
        cmd        = CMD_RD_ROOT;
        state_next = S_TAKE_ROOT;
      end
      S_TAKE_ROOT: begin
        cmd        = CMD_TAKE_V;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (flags.descend) begin
          if (flags.whole) begin
            cmd        = CMD_SPLIT;
            state_next = S_SPLIT2;
          end else begin
            cmd        = CMD_RD_L;
            state_next = S_RD_R;
          end
        end else begin
          state_next = flags.fits ? S_TAKE : S_FAIL;
        end
      end
      S_SPLIT2: begin
        cmd        = CMD_SPLIT2;
        state_next = S_CHECK;
      end
      S_RD_R: begin
        cmd        = CMD_RD_R;
        state_next = S_CHOOSE;
      end
      S_CHOOSE: begin
        if (flags.pick_ok) begin
          cmd        = CMD_CHOOSE;
          state_next = S_CHECK;
        end else begin
          state_next = S_FAIL;
        end
      end
      S_TAKE: begin
        cmd        = CMD_TAKE;
        state_next = S_UP;
      end
      S_FAIL: begin
        cmd        = CMD_FAIL;
        state_next = S_FIN;
      end
      S_FREE_SET: begin
        cmd        = CMD_FREE_SET;
        state_next = S_UP;
      end
      S_UP: begin
        if (flags.at_root) begin
          state_next = S_FIN;
        end else begin
          cmd        = CMD_UP_L;
          state_next = S_UP_R;
        end
      end
      S_UP_R: begin
        cmd        = CMD_UP_R;
        state_next = S_UP_W;
      end
      S_UP_W: begin
        cmd        = CMD_UP_W;
        state_next = S_UP;
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd            = CMD_OUT;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_SWEEP_RST;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP_RST;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### rtl/buddy_page_allocator.sv
// An allocation walks down the tree to a block that fits and, if it finds one, walks back up
// to the root to update the levels above; a free sets its block and walks up to the root;
// errors and no-ops go straight to the result. Words are handled one at a time, as set by the
// single read port of the tree memory; the next word waits until the last result is posted.
// Initialize clears all 2048 tree nodes, one per cycle, then seeds the tree from usable_pages.
// Reset runs the same clearing pass over all 2048 nodes; no word is accepted until it ends.
`include "buddy_page_allocator_defines.svh"
module buddy_page_allocator
  import bpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // op[1:0], page_count[12:2], page_offset[22:13]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // status[1:0], alloc_offset[11:2], pages_left[22:12]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data        // usable_pages
);

  cmd_t       cmd;
  bpa_flags_t flags;

  assign cfg_ready = 1'b1;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .flags     (flags),
    .cmd       (cmd),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready)
  );

  bpa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .flags     (flags),
    .in_data   (s_axis_tdata),
    .cfg_we    (cfg_valid),
    .cfg_value (cfg_data),
    .out_data  (m_axis_tdata)
  );

  `BPA_ASSERT_AFTER_RST(a_no_accept_after_rst, !s_axis_tready)
  `BPA_ASSERT_IMPL(a_free_bounded, m_axis_tvalid, m_axis_tdata[22:12] <= 11'd1024)
  `BPA_ASSERT_IMPL(a_status_legal, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3)
  `BPA_ASSERT_IMPL(a_offset_zero_on_error, m_axis_tvalid && m_axis_tdata[1:0] != ST_OK, m_axis_tdata[11:2] == 10'd0)

endmodule
